// ----- rtl/core/dat_pkg.sv -----
// Package of the delayed action timer table: sizes, field and index types,
// operation codes and the command and status structs between controller and datapath.
// Depends on nothing; every other file of the block imports it.
package dat_pkg;

  localparam int unsigned MaxEntries = 16;
  localparam int unsigned TimeBits   = 32;
  localparam int unsigned IdxW       = (MaxEntries > 1) ? $clog2(MaxEntries) : 1;
  localparam int unsigned CntW       = $clog2(MaxEntries + 1);

  typedef logic [31:0]         field_time_t;
  typedef logic [7:0]          action_t;
  typedef logic [TimeBits-1:0] time_t;
  typedef logic [IdxW-1:0]     idx_t;
  typedef logic [CntW-1:0]     cnt_t;

  typedef enum logic {
    OpTick = 1'b0,
    OpPush = 1'b1
  } op_e;

  typedef struct packed {
    logic cap;
    logic store;
    logic emit_push;
    logic rd_start;
    logic keep;
    logic fire;
    logic flush;
  } cmd_t;

  typedef struct packed {
    logic op_push;
    logic delay_zero;
    logic full;
    logic empty;
    logic r_zero;
    logic is_last;
    logic pend_valid;
    logic out_free;
  } stat_t;

  // Times are held in TimeBits bits; wider input bits are masked off.
  function automatic time_t to_time(field_time_t v);
    logic [63:0] w;
    w = {32'b0, v};
    return w[TimeBits-1:0];
  endfunction

endpackage

// ----- rtl/core/dat_item_if.sv -----
// Input channel of the delayed action timer table: valid, ready and one item.
// Depends on dat_pkg for the field types.
interface dat_item_if;
  import dat_pkg::*;

  logic        valid;
  logic        ready;
  logic        operation;
  field_time_t time_delta;
  field_time_t delay;
  action_t     action_id;

  modport source (output valid, operation, time_delta, delay, action_id, input ready);
  modport sink   (input valid, operation, time_delta, delay, action_id, output ready);
endinterface

// ----- rtl/core/dat_result_if.sv -----
// Output channel of the delayed action timer table: valid, ready and one result.
// Depends on dat_pkg for the field types.
interface dat_result_if;
  import dat_pkg::*;

  logic    valid;
  logic    ready;
  action_t fired_action;
  logic    dropped;
  logic    last;

  modport source (output valid, fired_action, dropped, last, input ready);
  modport sink   (input valid, fired_action, dropped, last, output ready);
endinterface

// ----- rtl/core/dat_ctrl.sv -----
// Controller of the delayed action timer table: decodes an item and sequences
// the table walk of a tick. Depends on dat_pkg for the command and status structs.
module dat_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  dat_pkg::stat_t stat_i,
  output dat_pkg::cmd_t  cmd_o
);
  import dat_pkg::*;

  typedef enum logic [1:0] {
    StIdle,
    StCmd,
    StEval,
    StFlush
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.cap = 1'b1;
          state_d   = StCmd;
        end
      end
      StCmd: begin
        if (stat_i.op_push) begin
          if (stat_i.delay_zero || stat_i.full) begin
            if (stat_i.out_free) begin
              cmd_o.emit_push = 1'b1;
              state_d         = StIdle;
            end
          end else begin
            cmd_o.store = 1'b1;
            state_d     = StIdle;
          end
        end else if (stat_i.empty) begin
          state_d = StIdle;
        end else begin
          cmd_o.rd_start = 1'b1;
          state_d        = StEval;
        end
      end
      StEval: begin
        if (!stat_i.r_zero) begin
          cmd_o.keep = 1'b1;
          if (stat_i.is_last) begin
            state_d = StFlush;
          end
        end else if (!stat_i.pend_valid || stat_i.out_free) begin
          cmd_o.fire = 1'b1;
          if (stat_i.is_last) begin
            state_d = StFlush;
          end
        end
      end
      StFlush: begin
        if (!stat_i.pend_valid) begin
          state_d = StIdle;
        end else if (stat_i.out_free) begin
          cmd_o.flush = 1'b1;
          state_d     = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ----- rtl/core/dat_datapath.sv -----
// Datapath of the delayed action timer table: item registers, the entry
// memories, the saturating subtract, the held fired action and the output
// register. Depends on dat_pkg and dat_item_if and dat_result_if.
module dat_datapath (
  input  logic           clk_i,
  input  logic           rst_ni,
  dat_item_if.sink       item_i,
  dat_result_if.source   result_o,
  input  dat_pkg::cmd_t  cmd_i,
  output dat_pkg::stat_t stat_o
);
  import dat_pkg::*;

  time_t   time_mem [MaxEntries];
  action_t act_mem  [MaxEntries];

  logic    op_q;
  time_t   dt_q;
  time_t   dl_q;
  action_t act_q;
  time_t   rd_time_q;
  action_t rd_act_q;
  cnt_t    cnt_q;
  cnt_t    idx_q;
  logic    pend_valid_q;
  action_t pend_act_q;
  logic    out_valid_q;
  action_t out_act_q;
  logic    out_drop_q;
  logic    out_last_q;

  logic    delay_zero;
  logic    r_zero;
  time_t   r_time;
  logic    is_last;
  logic    out_free;
  logic    we;
  cnt_t    waddr;
  time_t   wtime;
  action_t wact;
  logic    re;
  cnt_t    raddr;
  logic    out_load;
  action_t out_act_d;
  logic    out_drop_d;
  logic    out_last_d;

  assign delay_zero = (dl_q == '0);
  assign r_zero     = !(rd_time_q > dt_q);
  assign r_time     = r_zero ? '0 : (rd_time_q - dt_q);
  assign is_last    = (idx_q == (cnt_q - cnt_t'(1)));
  assign out_free   = !out_valid_q || result_o.ready;

  assign stat_o.op_push    = (op_q == OpPush);
  assign stat_o.delay_zero = delay_zero;
  assign stat_o.full       = (cnt_q == cnt_t'(MaxEntries));
  assign stat_o.empty      = (cnt_q == '0);
  assign stat_o.r_zero     = r_zero;
  assign stat_o.is_last    = is_last;
  assign stat_o.pend_valid = pend_valid_q;
  assign stat_o.out_free   = out_free;

  always_comb begin
    we    = cmd_i.store || cmd_i.keep;
    waddr = cmd_i.store ? cnt_q : idx_q;
    wtime = cmd_i.store ? dl_q : r_time;
    wact  = cmd_i.store ? act_q : rd_act_q;
    re    = cmd_i.rd_start || ((cmd_i.keep || cmd_i.fire) && !is_last);
    if (cmd_i.keep) begin
      raddr = idx_q + cnt_t'(1);
    end else if (cmd_i.fire) begin
      raddr = cnt_q - cnt_t'(1);
    end else begin
      raddr = '0;
    end
  end

  always_comb begin
    out_load   = 1'b0;
    out_act_d  = pend_act_q;
    out_drop_d = 1'b0;
    out_last_d = 1'b0;
    if (cmd_i.emit_push) begin
      out_load   = 1'b1;
      out_act_d  = delay_zero ? act_q : '0;
      out_drop_d = !delay_zero;
      out_last_d = 1'b1;
    end else if (cmd_i.fire && pend_valid_q) begin
      out_load = 1'b1;
    end else if (cmd_i.flush) begin
      out_load   = 1'b1;
      out_last_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      time_mem[waddr[IdxW-1:0]] <= wtime;
      act_mem[waddr[IdxW-1:0]]  <= wact;
    end
    if (re) begin
      rd_time_q <= time_mem[raddr[IdxW-1:0]];
      rd_act_q  <= act_mem[raddr[IdxW-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.cap) begin
      op_q  <= item_i.operation;
      dt_q  <= to_time(item_i.time_delta);
      dl_q  <= to_time(item_i.delay);
      act_q <= item_i.action_id;
      idx_q <= '0;
    end else if (cmd_i.keep) begin
      idx_q <= idx_q + cnt_t'(1);
    end
    if (cmd_i.fire) begin
      pend_act_q <= rd_act_q;
    end
    if (out_load) begin
      out_act_q  <= out_act_d;
      out_drop_q <= out_drop_d;
      out_last_q <= out_last_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q        <= '0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cmd_i.store) begin
        cnt_q <= cnt_q + cnt_t'(1);
      end else if (cmd_i.fire) begin
        cnt_q <= cnt_q - cnt_t'(1);
      end
      if (cmd_i.fire) begin
        pend_valid_q <= 1'b1;
      end else if (cmd_i.flush) begin
        pend_valid_q <= 1'b0;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (result_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign result_o.valid        = out_valid_q;
  assign result_o.fired_action = out_act_q;
  assign result_o.dropped      = out_drop_q;
  assign result_o.last         = out_last_q;

endmodule

// ----- rtl/core/delayed_action_timer_table_core.sv -----
// Top level of the delayed action timer table: joins controller and datapath.
// Depends on dat_pkg, dat_item_if, dat_result_if, dat_ctrl and dat_datapath.
//
// Items arrive on item_i and results leave on result_o; each transfer takes
// place when valid and ready are both high. A push stores a timer entry, or
// gives one result at once when its delay is zero or the table is full. A
// tick subtracts its elapsed time from every entry once and gives one result
// per expired entry, the final one marked by last; a tick that expires
// nothing gives no result.
// An item is taken only while the controller is idle. A push is captured and
// then stored or answered, its result coming from the output register. A tick
// is captured, starts the memory read and walks the entries one by one, where
// every entry costs one compare and subtract on the registered memory read.
// Reset empties the table; the entries need no clearing. When the receiver
// stalls, the finished result waits in the output register while the walk
// goes on until it meets an expired entry while one is already held, and then the walk pauses.
module delayed_action_timer_table_core (
  input  logic         clk_i,
  input  logic         rst_ni,
  dat_item_if.sink     item_i,
  dat_result_if.source result_o
);
  import dat_pkg::*;

  cmd_t  cmd;
  stat_t stat;
  logic  in_ready;

  assign item_i.ready = in_ready;

  dat_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (item_i.valid),
    .in_ready_o (in_ready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  dat_datapath u_datapath (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .item_i   (item_i),
    .result_o (result_o),
    .cmd_i    (cmd),
    .stat_o   (stat)
  );

  // A fired action never overwrites a held one while the output register is busy.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.fire |-> (!stat.pend_valid || stat.out_free))
    else $error("fired action lost to a stalled output");

  // No walk result is still held when a new item is taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    item_i.ready |-> !stat.pend_valid)
    else $error("held fired action left behind at idle");

  // At most one datapath command in any cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd.cap, cmd.store, cmd.emit_push, cmd.rd_start, cmd.keep, cmd.fire,
              cmd.flush}))
    else $error("conflicting datapath commands");

  // A rejected push is always the only and final result of its item.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_o.valid && result_o.dropped) |-> result_o.last)
    else $error("dropped result not marked last");

endmodule

// ----- dv/delayed_action_timer_table_core_tb.sv -----
// Testbench of delayed_action_timer_table_core: directed and random pushes and ticks, with
// the fired action and the dropped and last flags of every result checked against an in-bench timer model.
// Depends on dat_pkg, dat_item_if, dat_result_if and the core itself.
module delayed_action_timer_table_core_tb;
  import dat_pkg::*;

  localparam int unsigned RandomItems  = 95;
  localparam int unsigned IdlePercent  = 21;
  localparam int unsigned HoldCycles   = 300;
  localparam int unsigned FirstHoldAt  = 21;
  localparam int unsigned SecondHoldAt = 100;
  localparam int unsigned SteadyFrom   = 60;
  localparam int unsigned SteadyTo     = 90;
  localparam int unsigned SettleCycles = 40;
  localparam int unsigned StallLimit   = 2000;

  typedef struct {
    op_e         op;
    field_time_t time_delta;
    field_time_t delay;
    action_t     action_id;
    bit          drain;
  } timer_req_t;

  typedef struct packed {
    action_t action;
    logic    dropped;
    logic    last;
  } firing_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        send_valid = 1'b0;
  op_e         send_op = OpTick;
  field_time_t send_delta = '0;
  field_time_t send_delay = '0;
  action_t     send_action = '0;
  logic        take_ready = 1'b0;

  timer_req_t  pending_reqs[$];
  firing_t     firings_due[$];
  time_t       timer_left[MaxEntries];
  action_t     timer_action[MaxEntries];
  int unsigned timer_count;
  int unsigned results_owed = 0;
  int unsigned items_done = 0;
  int unsigned mismatches = 0;
  int unsigned hold_left = 0;
  int unsigned holds_done = 0;
  int unsigned quiet_cycles = 0;
  logic        steady;

  dat_item_if   item_bus ();
  dat_result_if result_bus ();

  assign item_bus.valid      = send_valid;
  assign item_bus.operation  = send_op;
  assign item_bus.time_delta = send_delta;
  assign item_bus.delay      = send_delay;
  assign item_bus.action_id  = send_action;
  assign result_bus.ready    = take_ready;

  assign steady = (items_done >= SteadyFrom) && (items_done < SteadyTo);

  delayed_action_timer_table_core DUT (
    .clk_i   (clk),
    .rst_ni  (rst_n),
    .item_i  (item_bus),
    .result_o(result_bus)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  task automatic flag_mismatch(input string what);
    $display("MISMATCH at %0t: %s", $realtime, what);
    mismatches++;
  endtask

  task automatic queue_push(input field_time_t dl, input action_t act, input bit drain);
    timer_req_t r;
    r.op         = OpPush;
    r.time_delta = $urandom;
    r.delay      = dl;
    r.action_id  = act;
    r.drain      = drain;
    pending_reqs.insert(pending_reqs.size(), r);
  endtask

  task automatic queue_tick(input field_time_t dt, input bit drain);
    timer_req_t r;
    r.op         = OpTick;
    r.time_delta = dt;
    r.delay      = $urandom;
    r.action_id  = action_t'($urandom_range(255));
    r.drain      = drain;
    pending_reqs.insert(pending_reqs.size(), r);
  endtask

  function automatic field_time_t random_span(input bit allow_zero);
    field_time_t v;
    case ($urandom_range(9))
      0:       v = allow_zero ? '0 : 32'd1;
      1, 2, 3, 4: v = $urandom_range(1, 16);
      5, 6, 7: v = $urandom_range(1, 32'h0002_0000);
      8:       v = '1;
      default: v = $urandom;
    endcase
    return v;
  endfunction

  task automatic predict_firings(input op_e op, input field_time_t dt_in,
                                 input field_time_t dl_in, input action_t act);
    time_t       dt;
    time_t       dl;
    time_t       r;
    firing_t     f;
    int unsigned i;
    int unsigned fired;
    int unsigned tail;
    dt    = time_t'(dt_in);
    dl    = time_t'(dl_in);
    fired = 0;
    if (op == OpPush) begin
      if (dl == '0) begin
        f = '{action: act, dropped: 1'b0, last: 1'b1};
        firings_due.insert(firings_due.size(), f);
      end else if (timer_count >= MaxEntries) begin
        f = '{action: '0, dropped: 1'b1, last: 1'b1};
        firings_due.insert(firings_due.size(), f);
      end else begin
        timer_left[timer_count]   = dl;
        timer_action[timer_count] = act;
        timer_count++;
      end
    end else begin
      i = 0;
      while (i < timer_count) begin
        r = timer_left[i];
        r = (r > dt) ? r - dt : '0;
        timer_left[i] = r;
        if (r == '0) begin
          f = '{action: timer_action[i], dropped: 1'b0, last: 1'b0};
          firings_due.insert(firings_due.size(), f);
          fired++;
          tail            = timer_count - 1;
          timer_left[i]   = timer_left[tail];
          timer_action[i] = timer_action[tail];
          timer_count     = tail;
        end else begin
          i++;
        end
      end
      if (fired != 0) begin
        firings_due[firings_due.size() - 1].last = 1'b1;
      end
    end
  endtask

  always @(posedge clk or negedge rst_n) begin : driver
    logic took;
    if (!rst_n) begin
      send_valid <= 1'b0;
    end else begin
      took = send_valid && item_bus.ready;
      if (took) begin
        void'(pending_reqs.pop_front());
      end
      if (!send_valid || took) begin
        if (pending_reqs.size() != 0 && (steady || $urandom_range(99) >= IdlePercent) &&
            !(pending_reqs[0].drain && (took || results_owed != 0))) begin
          send_valid  <= 1'b1;
          send_op     <= pending_reqs[0].op;
          send_delta  <= pending_reqs[0].time_delta;
          send_delay  <= pending_reqs[0].delay;
          send_action <= pending_reqs[0].action_id;
        end else begin
          send_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      take_ready <= 1'b0;
      hold_left  <= 0;
      holds_done <= 0;
    end else if (holds_done < 2 &&
                 items_done >= ((holds_done == 0) ? FirstHoldAt : SecondHoldAt)) begin
      take_ready <= 1'b0;
      hold_left  <= HoldCycles;
      holds_done <= holds_done + 1;
    end else if (hold_left != 0) begin
      take_ready <= 1'b0;
      hold_left  <= hold_left - 1;
    end else begin
      take_ready <= steady || ($urandom_range(99) >= IdlePercent);
    end
  end

  always @(posedge clk or negedge rst_n) begin : monitor
    firing_t want;
    if (!rst_n) begin
      timer_count = 0;
      firings_due.delete();
      results_owed <= 0;
      items_done   <= 0;
    end else begin
      if (item_bus.valid && item_bus.ready) begin
        predict_firings(op_e'(item_bus.operation), item_bus.time_delta, item_bus.delay,
                        item_bus.action_id);
        items_done <= items_done + 1;
      end
      if (result_bus.valid && result_bus.ready) begin
        if (firings_due.size() == 0) begin
          flag_mismatch($sformatf("unexpected result action %0h dropped %0b last %0b",
                                  result_bus.fired_action, result_bus.dropped,
                                  result_bus.last));
        end else begin
          want = firings_due.pop_front();
          if (result_bus.fired_action !== want.action) begin
            flag_mismatch($sformatf("fired_action %0h, expected %0h",
                                    result_bus.fired_action, want.action));
          end
          if (result_bus.dropped !== want.dropped) begin
            flag_mismatch($sformatf("dropped %0b, expected %0b",
                                    result_bus.dropped, want.dropped));
          end
          if (result_bus.last !== want.last) begin
            flag_mismatch($sformatf("last %0b, expected %0b", result_bus.last, want.last));
          end
        end
      end
      results_owed <= firings_due.size();
    end
  end

  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      quiet_cycles <= 0;
    end else if ((item_bus.valid && item_bus.ready) ||
                 (result_bus.valid && result_bus.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= StallLimit) begin
      $display("Some tests failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : stimulus
    field_time_t spans[16];
    int unsigned n;
    int unsigned burst;
    int unsigned k;
    spans = '{32'd1, 32'hFFFF_FFFF, 32'd3, 32'd100, 32'd2, 32'h8000_0000, 32'h0001_0000,
              32'd4, 32'h0000_FFFF, 32'd5, 32'h7FFF_FFFF, 32'd6, 32'h1234_5678, 32'd7,
              32'd8, 32'd2};

    // A tick on the empty table, immediate pushes, then a full table, its overflow and ticks on it.
    queue_tick('1, 1'b0);
    queue_push('0, 8'hFF, 1'b0);
    queue_push('0, 8'h00, 1'b0);
    for (k = 0; k < 16; k++) begin
      queue_push(spans[k], 8'hA0 + k[7:0], 1'b0);
    end
    queue_push(32'd5, 8'h5A, 1'b1);
    queue_push('0, 8'h3C, 1'b0);
    queue_tick('0, 1'b0);
    queue_tick(32'd8, 1'b0);
    queue_tick(32'd1, 1'b0);
    queue_tick('1, 1'b0);

    n = 0;
    while (n < RandomItems) begin
      k = $urandom_range(99);
      if (k < 8) begin
        burst = $urandom_range(14, 19);
        repeat (burst) queue_push($urandom_range(1, 40), action_t'($urandom_range(255)), 1'b0);
        n += burst;
      end else if (k < 50) begin
        queue_push(random_span(1'b1), action_t'($urandom_range(255)),
                   (n == 0) || ($urandom_range(24) == 0));
        n++;
      end else begin
        queue_tick(random_span(1'b1), (n == 0) || ($urandom_range(24) == 0));
        n++;
      end
    end

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    do begin
      @(negedge clk);
    end while (pending_reqs.size() != 0 || send_valid || firings_due.size() != 0);
    repeat (SettleCycles) @(posedge clk);
    @(negedge clk);
    if (firings_due.size() != 0) begin
      flag_mismatch($sformatf("%0d expected results never arrived", firings_due.size()));
    end
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
